[src/tbdd_pkg.sv]
// Shared types and constants for the test-bit sample detector.
package tbdd_pkg;

  // Number of watched voices; the voice field itself is two bits wide.
  localparam int unsigned VOICES = 3;
  localparam int unsigned VidxW  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 8;

  // Register offsets within a voice.
  localparam logic [2:0] OFS_FREQ_HI  = 3'd1;
  localparam logic [2:0] OFS_PULSE_LO = 3'd2;
  localparam logic [2:0] OFS_PULSE_HI = 3'd3;
  localparam logic [2:0] OFS_CONTROL  = 3'd4;

  // Control byte masks and the masked codes that drive the detectors.
  localparam logic [7:0] FREQ_MASK   = 8'h19;
  localparam logic [7:0] FREQ_START  = 8'h11;
  localparam logic [7:0] FREQ_TEST   = 8'h08;
  localparam logic [7:0] FREQ_TEST_G = 8'h09;
  localparam logic [7:0] FREQ_GATE   = 8'h01;
  localparam logic [7:0] PULSE_MASK  = 8'h49;
  localparam logic [7:0] PULSE_ARM   = 8'h49;
  localparam logic [7:0] PULSE_FIRE  = 8'h41;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FREQ_TIMEOUT  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_PULSE_TIMEOUT = 1'd1;

  // Reset values of the timeouts.
  localparam logic [7:0] FREQ_TIMEOUT_RST  = 8'd12;
  localparam logic [7:0] PULSE_TIMEOUT_RST = 8'd7;

  typedef enum logic [2:0] {
    FOP_NONE,
    FOP_START,
    FOP_SET,
    FOP_GATE,
    FOP_FREQ_HI
  } freq_op_e;

  typedef enum logic [1:0] {
    POP_NONE,
    POP_ARM,
    POP_FIRE,
    POP_LOAD
  } pulse_op_e;

  typedef struct packed {
    logic [1:0]  voice_index;
    logic [2:0]  reg_offset;
    logic [7:0]  write_byte;
    logic [31:0] cycle_now;
  } in_word_t;

  typedef struct packed {
    logic       sample_found;
    logic [7:0] sample_level;
    logic [1:0] sample_voice;
    logic       found_by_pulse;
    logic       mute_voice;
  } out_word_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic [1:0]  voice;
    freq_op_e    fop;
    pulse_op_e   pop;
    logic        from_high;
    logic [7:0]  data;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [7:0] freq_timeout;
    logic [7:0] pulse_timeout;
  } cfg_t;

endpackage

[src/tbdd_front.sv]
// Front end: accepts register-write words and classifies them per detector.
module tbdd_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tbdd_pkg::in_word_t in_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output tbdd_pkg::cmd_t     q_cmd_o
);

  logic       voice_ok;
  logic [7:0] fmask;
  logic [7:0] pmask;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  // Decode offset and masked control codes into detector operations.
  always_comb begin
    voice_ok = (32'(in_data_i.voice_index) < tbdd_pkg::VOICES);
    fmask    = in_data_i.write_byte & tbdd_pkg::FREQ_MASK;
    pmask    = in_data_i.write_byte & tbdd_pkg::PULSE_MASK;

    q_cmd_o.voice     = voice_ok ? in_data_i.voice_index : 2'd0;
    q_cmd_o.fop       = tbdd_pkg::FOP_NONE;
    q_cmd_o.pop       = tbdd_pkg::POP_NONE;
    q_cmd_o.from_high = (in_data_i.reg_offset == tbdd_pkg::OFS_PULSE_HI);
    q_cmd_o.data      = in_data_i.write_byte;
    q_cmd_o.now       = in_data_i.cycle_now;

    if (voice_ok) begin
      case (in_data_i.reg_offset)
        tbdd_pkg::OFS_CONTROL: begin
          if (fmask == tbdd_pkg::FREQ_START) begin
            q_cmd_o.fop = tbdd_pkg::FOP_START;
          end else if (fmask == tbdd_pkg::FREQ_TEST || fmask == tbdd_pkg::FREQ_TEST_G) begin
            q_cmd_o.fop = tbdd_pkg::FOP_SET;
          end else if (fmask == tbdd_pkg::FREQ_GATE) begin
            q_cmd_o.fop = tbdd_pkg::FOP_GATE;
          end
          if (pmask == tbdd_pkg::PULSE_ARM) begin
            q_cmd_o.pop = tbdd_pkg::POP_ARM;
          end else if (pmask == tbdd_pkg::PULSE_FIRE) begin
            q_cmd_o.pop = tbdd_pkg::POP_FIRE;
          end
        end
        tbdd_pkg::OFS_FREQ_HI: begin
          q_cmd_o.fop = tbdd_pkg::FOP_FREQ_HI;
        end
        tbdd_pkg::OFS_PULSE_LO, tbdd_pkg::OFS_PULSE_HI: begin
          q_cmd_o.pop = tbdd_pkg::POP_LOAD;
        end
        default: begin
          q_cmd_o.fop = tbdd_pkg::FOP_NONE;
        end
      endcase
    end
  end

endmodule

[src/tbdd_queue.sv]
// Two-entry queue of classified words between front and back.
module tbdd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tbdd_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output tbdd_pkg::cmd_t cmd_o
);

  tbdd_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[src/tbdd_back.sv]
// Back end: per-voice frequency and pulse detectors and the output register.
module tbdd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tbdd_pkg::cfg_t      cfg_i,
  input  logic                q_empty_i,
  input  tbdd_pkg::cmd_t      q_cmd_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tbdd_pkg::out_word_t out_data_o
);

  typedef enum logic [2:0] {
    FPH_IDLE,
    FPH_PREP,
    FPH_SET,
    FPH_GATED,
    FPH_HELD
  } fph_e;

  typedef enum logic [2:0] {
    PPH_IDLE,
    PPH_PREP,
    PPH_CONFIRM,
    PPH_TEST_FIRST,
    PPH_CONFIRM2
  } pph_e;

  fph_e        fphase_q [tbdd_pkg::VOICES];
  logic [31:0] fstamp_q [tbdd_pkg::VOICES];
  logic [7:0]  fheld_q  [tbdd_pkg::VOICES];
  pph_e        pphase_q [tbdd_pkg::VOICES];
  logic [31:0] pstamp_q [tbdd_pkg::VOICES];
  logic [7:0]  pheld_q  [tbdd_pkg::VOICES];
  logic        phigh_q  [tbdd_pkg::VOICES];

  logic                    out_valid_q;
  tbdd_pkg::out_word_t     out_q, out_d;
  logic [tbdd_pkg::VidxW-1:0] vidx;

  fph_e        fph, fphase_d;
  logic [31:0] fstamp_d;
  logic [7:0]  fheld_d;
  pph_e        pph, pphase_d;
  logic [31:0] pstamp_d;
  logic [7:0]  pheld_d;
  logic        phigh_d;
  logic [31:0] fdiff, pdiff;
  logic        fok, pok;
  logic        fhit, phit;
  logic [7:0]  level;

  assign q_pop_o     = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign vidx        = tbdd_pkg::VidxW'(q_cmd_i.voice);

  // Next state of the addressed voice and the result word.
  always_comb begin
    fph      = fphase_q[vidx];
    pph      = pphase_q[vidx];
    fphase_d = fph;
    fstamp_d = fstamp_q[vidx];
    fheld_d  = fheld_q[vidx];
    pphase_d = pph;
    pstamp_d = pstamp_q[vidx];
    pheld_d  = pheld_q[vidx];
    phigh_d  = phigh_q[vidx];
    fdiff    = q_cmd_i.now - fstamp_q[vidx];
    pdiff    = q_cmd_i.now - pstamp_q[vidx];
    fok      = fdiff < {24'd0, cfg_i.freq_timeout};
    pok      = pdiff < {24'd0, cfg_i.pulse_timeout};
    fhit     = 1'b0;
    phit     = 1'b0;
    level    = 8'd0;

    // Frequency detector runs first.
    case (q_cmd_i.fop)
      tbdd_pkg::FOP_START: begin
        fphase_d = FPH_PREP;
        fstamp_d = q_cmd_i.now;
      end
      tbdd_pkg::FOP_SET: begin
        if (fph == FPH_PREP && fok) begin
          fphase_d = FPH_SET;
          fstamp_d = q_cmd_i.now;
        end else begin
          fphase_d = FPH_IDLE;
        end
      end
      tbdd_pkg::FOP_GATE: begin
        if (fph == FPH_SET && fok) begin
          fphase_d = FPH_GATED;
          fstamp_d = q_cmd_i.now;
        end else if (fph == FPH_HELD && fok) begin
          fhit  = 1'b1;
          level = fheld_q[vidx];
        end else begin
          fphase_d = FPH_IDLE;
        end
      end
      tbdd_pkg::FOP_FREQ_HI: begin
        if (fph == FPH_SET && fok) begin
          fheld_d  = q_cmd_i.data;
          fphase_d = FPH_HELD;
          fstamp_d = q_cmd_i.now;
        end else if (fph == FPH_GATED && fok) begin
          fhit  = 1'b1;
          level = q_cmd_i.data;
        end
      end
      default: begin
        fhit = 1'b0;
      end
    endcase

    // Pulse detector only when the frequency detector did not fire.
    if (!fhit) begin
      case (q_cmd_i.pop)
        tbdd_pkg::POP_ARM: begin
          pphase_d = (pph == PPH_PREP && pok) ? PPH_CONFIRM : PPH_TEST_FIRST;
          pstamp_d = q_cmd_i.now;
        end
        tbdd_pkg::POP_FIRE: begin
          pphase_d = PPH_IDLE;
          if ((pph == PPH_CONFIRM || pph == PPH_CONFIRM2) && pok) begin
            phit  = 1'b1;
            level = phigh_q[vidx] ? {pheld_q[vidx][3:0], 4'd0} : pheld_q[vidx];
          end
        end
        tbdd_pkg::POP_LOAD: begin
          pphase_d = (pph == PPH_TEST_FIRST && pok) ? PPH_CONFIRM2 : PPH_PREP;
          pstamp_d = q_cmd_i.now;
          pheld_d  = q_cmd_i.data;
          phigh_d  = q_cmd_i.from_high;
        end
        default: begin
          phit = 1'b0;
        end
      endcase
    end

    // Any hit idles the frequency detector.
    if (fhit || phit) begin
      fphase_d = FPH_IDLE;
      fstamp_d = 32'd0;
    end

    out_d.sample_found   = fhit || phit;
    out_d.sample_level   = level;
    out_d.sample_voice   = (fhit || phit) ? q_cmd_i.voice : 2'd0;
    out_d.found_by_pulse = phit;
    out_d.mute_voice     = phit;
  end

  // Detector state, written for the addressed voice on each taken word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tbdd_pkg::VOICES; i++) begin
        fphase_q[i] <= FPH_IDLE;
        fstamp_q[i] <= 32'd0;
        fheld_q[i]  <= 8'd0;
        pphase_q[i] <= PPH_IDLE;
        pstamp_q[i] <= 32'd0;
        pheld_q[i]  <= 8'd0;
        phigh_q[i]  <= 1'b0;
      end
    end else if (q_pop_o) begin
      fphase_q[vidx] <= fphase_d;
      fstamp_q[vidx] <= fstamp_d;
      fheld_q[vidx]  <= fheld_d;
      pphase_q[vidx] <= pphase_d;
      pstamp_q[vidx] <= pstamp_d;
      pheld_q[vidx]  <= pheld_d;
      phigh_q[vidx]  <= phigh_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word; held while stalled.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

endmodule

[src/test_bit_digi_detector_unit.sv]
// Top level of the test-bit sample detector: front, queue, back and config registers.
//
//   Channel  Direction  Word         Handshake
//   in       input      in_data_i    in_valid_i / in_stall_o
//   out      output     out_data_o   out_valid_o / out_stall_i
//   cfg      input      cfg_data_i   cfg_we_i, cfg_idx_i
//
// One word is accepted per cycle while in_stall_o is low, and each gives exactly one
// result word. The word is first written into the two-entry queue; the edge that pops
// it loads the output register, and no pop happens while the output is stalled.
// State is read and written in the same cycle: one word per clock unless stalled.
// Reset clears all detector state and restores the default timeouts.
// An output stall fills the queue, after which in_stall_o rises.
module test_bit_digi_detector_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  tbdd_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output tbdd_pkg::out_word_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [tbdd_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [tbdd_pkg::CfgDataW-1:0]     cfg_data_i
);

  tbdd_pkg::cfg_t cfg_q;
  tbdd_pkg::cmd_t push_cmd;
  tbdd_pkg::cmd_t head_cmd;
  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.freq_timeout  <= tbdd_pkg::FREQ_TIMEOUT_RST;
      cfg_q.pulse_timeout <= tbdd_pkg::PULSE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tbdd_pkg::CFG_FREQ_TIMEOUT:  cfg_q.freq_timeout  <= cfg_data_i;
        tbdd_pkg::CFG_PULSE_TIMEOUT: cfg_q.pulse_timeout <= cfg_data_i;
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  tbdd_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (push_cmd)
  );

  tbdd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  tbdd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
